FILE: sv/ttlh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttlh_pkg
// Shared types and constants of the TTL expiry heap table.
// ----------------------------------------------------------------------------
package ttlh_pkg;

  localparam int DEF_CAPACITY = 16;
  localparam int MAX_RESULTS  = 16;
  localparam int POP_W        = 5;

  localparam logic [2:0] CMD_INSERT = 3'd0;
  localparam logic [2:0] CMD_GET    = 3'd1;
  localparam logic [2:0] CMD_ERASE  = 3'd2;
  localparam logic [2:0] CMD_EXPIRE = 3'd3;
  localparam logic [2:0] CMD_CLEAR  = 3'd4;
  localparam logic [2:0] CMD_TICK   = 3'd5;

  // one heap node: key, expiry tick and stored value
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] expiry;
    logic [31:0] value;
  } ent_t;

  typedef struct packed {
    logic        found;
    logic [31:0] key;
    logic [31:0] value;
    logic [4:0]  live;
    logic        rejected;
    logic        last;
  } res_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PC_RD, ST_PC_CK, ST_PP_LAST, ST_FD_RD, ST_FD_CK, ST_CP_RD, ST_CP_WR,
    ST_HP, ST_SD_LD, ST_SD_L, ST_SD_R, ST_SD_C, ST_INS, ST_SU, ST_SU_C, ST_RESP,
    ST_EM_RD, ST_EM_WR
  } state_t;

endpackage
`default_nettype wire

FILE: sv/ttl_expiry_heap_table.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttl_expiry_heap_table
// Key-value table with time-to-live, expiry ordered by a min-heap in memory.
// ----------------------------------------------------------------------------
// Channel | Dir | Transfer contents
// s_axis  | in  | tuser: command; tdata: key, value, ttl
// m_axis  | out | tdata: found, out_key, out_value, live_count, rejected; tlast
//
// One command at a time; each memory access is a read state followed by a
// compare state. Lookup walks the heap linearly (FD_RD, FD_CK per entry);
// erase adds a shift of the tail (CP_RD, CP_WR per entry) and a bottom-up
// rebuild; a pop sifts down through SD_L, SD_R and SD_C per level, an insert
// sifts up through SU and SU_C per level. Results wait in the output
// register; a stalled sink holds the sequencer at its next result.
// Synchronous reset empties the heap at once, node contents need no clearing.
// ----------------------------------------------------------------------------
module ttl_expiry_heap_table
  import ttlh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [87:0] s_axis_tdata,  // key[31:0], value[63:32], ttl[83:64]
  input  wire logic [2:0]  s_axis_tuser,  // command
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // found, out_key, out_value, live_count,
                                          // rejected
  output logic             m_axis_tlast
);

  localparam int IW = $clog2(CAPACITY);
  localparam int SW = $clog2(CAPACITY + 1);

  state_t          state, state_next;
  logic [2:0]      cmd, cmd_next;
  logic [31:0]     key, key_next, val, val_next, exp, exp_next;
  logic [31:0]     now, now_next;
  logic [SW-1:0]   size, size_next, idx, idx_next, hi, hi_next;
  logic [IW-1:0]   i, i_next;
  logic [POP_W-1:0] pops, pops_next;
  ent_t            cur, cur_next, lft, lft_next, top_e, top_next;
  logic            rvalid, rvalid_next, ret_pop, ret_pop_next;
  logic            fnd, fnd_next, rej, rej_next;
  logic [31:0]     oval, oval_next;

  logic            wen, ren;
  logic [IW-1:0]   waddr, raddr;
  ent_t            wdata, rd;
  logic            out_load, out_free;
  res_t            res;

  logic [32:0]     exp_sum;
  logic [IW+1:0]   lidx, ridx;
  logic [IW-1:0]   pidx;

  ttlh_mem #(.DEPTH(CAPACITY), .AW(IW)) u_mem (
    .clk   (clk),
    .wen   (wen),
    .waddr (waddr),
    .wdata (wdata),
    .ren   (ren),
    .raddr (raddr),
    .rdata (rd)
  );

  ttlh_out u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (out_load),
    .res    (res),
    .free   (out_free),
    .tvalid (m_axis_tvalid),
    .tready (m_axis_tready),
    .tdata  (m_axis_tdata),
    .tlast  (m_axis_tlast)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign exp_sum = {1'b0, now} + {13'd0, s_axis_tdata[83:64]};
  assign lidx    = {1'b0, i, 1'b1};
  assign ridx    = lidx + (IW+2)'(1);
  assign pidx    = (i - IW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      size  <= '0;
      now   <= '0;
    end else begin
      state <= state_next;
      size  <= size_next;
      now   <= now_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd     <= cmd_next;
    key     <= key_next;
    val     <= val_next;
    exp     <= exp_next;
    idx     <= idx_next;
    hi      <= hi_next;
    i       <= i_next;
    pops    <= pops_next;
    cur     <= cur_next;
    lft     <= lft_next;
    top_e   <= top_next;
    rvalid  <= rvalid_next;
    ret_pop <= ret_pop_next;
    fnd     <= fnd_next;
    rej     <= rej_next;
    oval    <= oval_next;
  end

  always_comb begin
    state_next   = state;
    cmd_next     = cmd;
    key_next     = key;
    val_next     = val;
    exp_next     = exp;
    now_next     = now;
    size_next    = size;
    idx_next     = idx;
    hi_next      = hi;
    i_next       = i;
    pops_next    = pops;
    cur_next     = cur;
    lft_next     = lft;
    top_next     = top_e;
    rvalid_next  = rvalid;
    ret_pop_next = ret_pop;
    fnd_next     = fnd;
    rej_next     = rej;
    oval_next    = oval;
    wen          = 1'b0;
    waddr        = '0;
    wdata        = cur;
    ren          = 1'b0;
    raddr        = '0;
    out_load     = 1'b0;
    res          = '0;
    res.live     = 5'(size);

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_next  = s_axis_tuser;
          key_next  = s_axis_tdata[31:0];
          val_next  = s_axis_tdata[63:32];
          exp_next  = exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
          fnd_next  = 1'b0;
          rej_next  = 1'b0;
          oval_next = '0;
          pops_next = '0;
          idx_next  = '0;
          case (s_axis_tuser)
            CMD_INSERT, CMD_ERASE: state_next = ST_FD_RD;
            CMD_GET, CMD_EXPIRE:   state_next = ST_PC_RD;
            CMD_CLEAR: begin
              size_next  = '0;
              state_next = ST_RESP;
            end
            CMD_TICK: begin
              if (now != 32'hFFFF_FFFF) now_next = now + 32'd1;
              state_next = ST_RESP;
            end
            default: state_next = ST_RESP;
          endcase
        end
      end

      // expiry sweep: test the heap top
      ST_PC_RD: begin
        if (size == '0 || (cmd == CMD_EXPIRE && pops == POP_W'(MAX_RESULTS))) begin
          if (cmd == CMD_GET) begin
            idx_next   = '0;
            state_next = ST_FD_RD;
          end else if (pops == '0) begin
            state_next = ST_RESP;
          end else begin
            // popped nodes sit just beyond the heap, first pop highest
            idx_next   = SW'(size + SW'(pops) - SW'(1));
            state_next = ST_EM_RD;
          end
        end else begin
          ren        = 1'b1;
          raddr      = '0;
          state_next = ST_PC_CK;
        end
      end

      ST_PC_CK: begin
        if (rd.expiry <= now) begin
          top_next   = rd;
          ren        = 1'b1;
          raddr      = IW'(size - SW'(1));
          state_next = ST_PP_LAST;
        end else begin
          // reuse the not-expired branch of the sweep end
          if (cmd == CMD_GET) begin
            idx_next   = '0;
            state_next = ST_FD_RD;
          end else if (pops == '0) begin
            state_next = ST_RESP;
          end else begin
            idx_next   = SW'(size + SW'(pops) - SW'(1));
            state_next = ST_EM_RD;
          end
        end
      end

      ST_PP_LAST: begin
        cur_next     = rd;
        wen          = 1'b1;
        waddr        = IW'(size - SW'(1));
        wdata        = top_e;
        size_next    = size - SW'(1);
        pops_next    = pops + POP_W'(1);
        i_next       = '0;
        ret_pop_next = 1'b1;
        state_next   = (size == SW'(1)) ? ST_PC_RD : ST_SD_L;
      end

      // linear key search
      ST_FD_RD: begin
        if (idx >= size) begin
          state_next = (cmd == CMD_INSERT) ? ST_INS : ST_RESP;
        end else begin
          ren        = 1'b1;
          raddr      = IW'(idx);
          state_next = ST_FD_CK;
        end
      end

      ST_FD_CK: begin
        idx_next = idx + SW'(1);
        if (rd.key == key) begin
          if (cmd == CMD_GET) begin
            fnd_next   = 1'b1;
            oval_next  = rd.value;
            state_next = ST_RESP;
          end else begin
            state_next = ST_CP_RD;
          end
        end else begin
          state_next = ST_FD_RD;
        end
      end

      // close the gap left by the erased node
      ST_CP_RD: begin
        if (idx >= size) begin
          size_next  = size - SW'(1);
          hi_next    = (size - SW'(1)) >> 1;
          state_next = ST_HP;
        end else begin
          ren        = 1'b1;
          raddr      = IW'(idx);
          state_next = ST_CP_WR;
        end
      end

      ST_CP_WR: begin
        wen        = 1'b1;
        waddr      = IW'(idx - SW'(1));
        wdata      = rd;
        idx_next   = idx + SW'(1);
        state_next = ST_CP_RD;
      end

      // bottom-up rebuild
      ST_HP: begin
        if (hi == '0) begin
          if (cmd == CMD_INSERT) begin
            state_next = ST_INS;
          end else begin
            fnd_next   = 1'b1;
            state_next = ST_RESP;
          end
        end else begin
          i_next       = IW'(hi - SW'(1));
          hi_next      = hi - SW'(1);
          ren          = 1'b1;
          raddr        = IW'(hi - SW'(1));
          ret_pop_next = 1'b0;
          state_next   = ST_SD_LD;
        end
      end

      ST_SD_LD: begin
        cur_next   = rd;
        state_next = ST_SD_L;
      end

      // sift down: cur is held, children move up into the hole
      ST_SD_L: begin
        if (lidx >= (IW+2)'(size)) begin
          wen        = 1'b1;
          waddr      = i;
          wdata      = cur;
          state_next = ret_pop ? ST_PC_RD : ST_HP;
        end else begin
          ren        = 1'b1;
          raddr      = IW'(lidx);
          state_next = ST_SD_R;
        end
      end

      ST_SD_R: begin
        lft_next = rd;
        if (ridx < (IW+2)'(size)) begin
          ren         = 1'b1;
          raddr       = IW'(ridx);
          rvalid_next = 1'b1;
        end else begin
          rvalid_next = 1'b0;
        end
        state_next = ST_SD_C;
      end

      ST_SD_C: begin
        wen   = 1'b1;
        waddr = i;
        if (lft.expiry < cur.expiry) begin
          if (rvalid && rd.expiry < lft.expiry) begin
            wdata  = rd;
            i_next = IW'(ridx);
          end else begin
            wdata  = lft;
            i_next = IW'(lidx);
          end
          state_next = ST_SD_L;
        end else if (rvalid && rd.expiry < cur.expiry) begin
          wdata      = rd;
          i_next     = IW'(ridx);
          state_next = ST_SD_L;
        end else begin
          wdata      = cur;
          state_next = ret_pop ? ST_PC_RD : ST_HP;
        end
      end

      ST_INS: begin
        if (size == SW'(CAPACITY)) begin
          rej_next   = 1'b1;
          state_next = ST_RESP;
        end else begin
          cur_next   = '{key: key, expiry: exp, value: val};
          i_next     = IW'(size);
          size_next  = size + SW'(1);
          state_next = ST_SU;
        end
      end

      // sift up: moves past a parent of equal expiry
      ST_SU: begin
        if (i == '0) begin
          wen        = 1'b1;
          waddr      = '0;
          wdata      = cur;
          state_next = ST_RESP;
        end else begin
          ren        = 1'b1;
          raddr      = pidx;
          state_next = ST_SU_C;
        end
      end

      ST_SU_C: begin
        wen   = 1'b1;
        waddr = i;
        if (rd.expiry < cur.expiry) begin
          wdata      = cur;
          state_next = ST_RESP;
        end else begin
          wdata      = rd;
          i_next     = pidx;
          state_next = ST_SU;
        end
      end

      ST_RESP: begin
        if (out_free) begin
          out_load     = 1'b1;
          res.found    = fnd;
          res.value    = oval;
          res.rejected = rej;
          res.last     = 1'b1;
          state_next   = ST_IDLE;
        end
      end

      ST_EM_RD: begin
        ren        = 1'b1;
        raddr      = IW'(idx);
        state_next = ST_EM_WR;
      end

      ST_EM_WR: begin
        if (out_free) begin
          out_load   = 1'b1;
          res.found  = 1'b1;
          res.key    = rd.key;
          res.last   = (pops == POP_W'(1));
          pops_next  = pops - POP_W'(1);
          idx_next   = idx - SW'(1);
          state_next = (pops == POP_W'(1)) ? ST_IDLE : ST_EM_RD;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/ttlh_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttlh_mem
// Heap node store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ttlh_mem
  import ttlh_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wen,
  input  wire logic [AW-1:0] waddr,
  input  wire ent_t          wdata,
  input  wire logic          ren,
  input  wire logic [AW-1:0] raddr,
  output ent_t               rdata
);

  ent_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: sv/ttlh_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ttlh_out
// Result output register on the master-side stream.
// ----------------------------------------------------------------------------
module ttlh_out
  import ttlh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  load,
  input  wire res_t  res,
  output logic       free,
  output logic       tvalid,
  input  wire logic  tready,
  output logic [71:0] tdata,
  output logic       tlast
);

  assign free = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tdata <= {1'b0, res.rejected, res.live, res.value, res.key, res.found};
      tlast <= res.last;
    end
  end

endmodule
`default_nettype wire
